>>> rtl/imd_pkg.sv
// ============================================================================
// IMU motion detector package
// Shared types, widths, register indexes and reset values of the detector.
// ============================================================================
package imd_pkg;

    localparam int SAMPLE_W   = 16;   // one signed Q4.12 axis
    localparam int MAG_W      = 17;   // magnitude of a 16-bit signed value
    localparam int NORM_W     = 20;   // squared norm, Q.12
    localparam int DEV_W      = 40;   // squared deviation, Q.24
    localparam int RATE_W     = 15;   // gyro threshold
    localparam int MUL_W      = 20;   // operand width of the shared multiplier
    localparam int PROD_W     = 40;   // product width of the shared multiplier
    localparam int ACC_W      = 32;   // sum of three squared axes
    localparam int Q_SHIFT    = 12;   // Q.24 to Q.12
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [NORM_W-1:0] NORM_LOW_RST       = 20'd3482;
    localparam logic [NORM_W-1:0] NORM_HIGH_RST      = 20'd4710;
    localparam logic [DEV_W-1:0]  VARIANCE_LIMIT_RST = 40'd8389;
    localparam logic [RATE_W-1:0] RATE_LIMIT_RST     = 15'd82;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORM_LOW       = 2'd0,
        REG_NORM_HIGH      = 2'd1,
        REG_VARIANCE_LIMIT = 2'd2,
        REG_RATE_LIMIT     = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_NORM, ST_NPUSH, ST_NDIV,
        ST_NWAIT, ST_DIFF, ST_DSQ, ST_DPUSH, ST_DDIV, ST_DWAIT, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_NORM, OP_NPUSH,
        OP_NDIV, OP_NMEAN, OP_DIFF, OP_DSQ, OP_DPUSH, OP_DDIV, OP_DMEAN,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

    // Exact magnitude of a signed 16-bit value; -32768 gives 32768.
    function automatic logic [MAG_W-1:0] mag16(input logic [SAMPLE_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[SAMPLE_W-1], v};
        return v[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
    endfunction

endpackage

>>> rtl/imu_motion_detector.sv
// ============================================================================
// IMU motion detector
// Flags motion from one accelerometer and gyro sample per item.
// ============================================================================
// Each input item is one IMU sample: three accelerometer axes and three gyro
// axes, signed Q4.12. For every item the block returns exactly one result
// item with four flags. strong_accel is set when the squared acceleration
// norm (Q.12, truncated) lies outside [norm_low, norm_high]; an inverted band
// makes it always set. accel_unsteady is set when the mean of the squared
// deviation of the norm from its running mean reaches variance_limit.
// rotating is set when any gyro magnitude reaches rate_limit, and moving is
// the OR of the three. Both running means cover the last NORM_WINDOW and
// DEVIATION_WINDOW samples and divide by the number of samples seen so far
// until their window is full; reset empties both windows, while
// configuration writes leave them untouched. Items are handled one at a
// time. Both divisions run on one shared restoring divider that retires one
// quotient bit per cycle over W bits, the wider of the two window totals:
// W = max(20 + clog2(NORM_WINDOW), 40 + clog2(DEVIATION_WINDOW)). With the
// default windows W is 44. The next item can be accepted in the cycle in
// which a result becomes valid. A finished result waits in an output
// register while the next item is already accepted; only when a result is
// still waiting as the next one finishes does the block stall until the
// receiver takes it. Configuration writes are always taken at once and
// should only be issued while no item is in flight.
// ============================================================================
module imu_motion_detector #(
    parameter int NORM_WINDOW      = 16,
    parameter int DEVIATION_WINDOW = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Sample input.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // From bit 0 up: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
    // each 16 bits, signed Q4.12.
    input  logic [imd_pkg::S_TDATA_W-1:0]    s_tdata,

    // Result output.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0 up: moving, strong_accel, accel_unsteady, rotating,
    // then four zero bits.
    output logic [imd_pkg::M_TDATA_W-1:0]    m_tdata,

    // Register writes: index 0 norm_low, 1 norm_high, 2 variance_limit,
    // 3 rate_limit. Bits above a register's width are dropped.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [imd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    imd_pkg::dp_cmd_t  cmd;
    imd_pkg::dp_stat_t stat;

    // Registers live in flip-flops, so a write never has to wait.
    assign cfg_ready = 1'b1;

    // The controller steps each sample through the datapath and holds the
    // result valid until the consumer takes it.
    imd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the registers, the two sample windows, the shared
    // multiplier and the divider, and builds the result flags.
    imd_datapath #(
        .NORM_WINDOW      (NORM_WINDOW),
        .DEVIATION_WINDOW (DEVIATION_WINDOW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (m_tdata)
    );

endmodule

>>> rtl/imd_div.sv
// ============================================================================
// IMU motion detector divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module imd_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;

    logic [DEN_W:0]   trial, trial_sub;
    logic             ge;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;

endmodule

>>> rtl/imd_datapath.sv
// ============================================================================
// IMU motion detector datapath
// Sample registers, shared multiplier, both sliding windows, divider and flags.
// ============================================================================
module imd_datapath #(
    parameter int NORM_WINDOW      = 16,
    parameter int DEVIATION_WINDOW = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  imd_pkg::dp_cmd_t                 cmd,
    output imd_pkg::dp_stat_t                stat,
    input  logic [imd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             cfg_wr,
    input  logic [imd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [imd_pkg::M_TDATA_W-1:0]    result
);

    localparam int NW   = imd_pkg::NORM_W;
    localparam int DW   = imd_pkg::DEV_W;
    localparam int SW   = imd_pkg::SAMPLE_W;
    localparam int NT_W = NW + $clog2(NORM_WINDOW);
    localparam int DT_W = DW + $clog2(DEVIATION_WINDOW);
    localparam int NF_W = $clog2(NORM_WINDOW + 1);
    localparam int DF_W = $clog2(DEVIATION_WINDOW + 1);
    localparam int NS_W = (NORM_WINDOW > 1) ? $clog2(NORM_WINDOW) : 1;
    localparam int DS_W = (DEVIATION_WINDOW > 1) ? $clog2(DEVIATION_WINDOW) : 1;
    localparam int DIVN_W = (NT_W > DT_W) ? NT_W : DT_W;
    localparam int DIVD_W = (NF_W > DF_W) ? NF_W : DF_W;

    // Configuration registers.
    logic [NW-1:0]                    norm_low_reg, norm_high_reg;
    logic [DW-1:0]                    var_limit_reg;
    logic [imd_pkg::RATE_W-1:0]       rate_limit_reg;

    // Sample and arithmetic registers.
    logic [SW-1:0]                    ax_reg, ay_reg, az_reg, rx_reg, ry_reg, rz_reg;
    logic [imd_pkg::PROD_W-1:0]       prod_reg;
    logic [imd_pkg::ACC_W-1:0]        acc_reg;
    logic [NW-1:0]                    norm_reg, mean_reg, diff_reg;
    logic                             strong_reg, unsteady_reg, rot_reg;
    logic [imd_pkg::M_TDATA_W-1:0]    result_reg;

    // Window state.
    logic [NW-1:0]   norm_mem [NORM_WINDOW];
    logic [DW-1:0]   dev_mem  [DEVIATION_WINDOW];
    logic [NW-1:0]   norm_rd_reg;
    logic [DW-1:0]   dev_rd_reg;
    logic [NT_W-1:0] norm_total_reg;
    logic [DT_W-1:0] dev_total_reg;
    logic [NF_W-1:0] norm_filled_reg;
    logic [DF_W-1:0] dev_filled_reg;
    logic [NS_W-1:0] norm_slot_reg;
    logic [DS_W-1:0] dev_slot_reg;

    logic [imd_pkg::MUL_W-1:0]  mul_a;
    logic [imd_pkg::PROD_W-1:0] mul_p;
    logic [imd_pkg::ACC_W-1:0]  sum3;
    logic [NW-1:0]              norm_old;
    logic [DW-1:0]              dev_old;
    logic [imd_pkg::MAG_W-1:0]  rate_lim_ext;
    logic                       div_start;
    logic [DIVN_W-1:0]          div_num, div_quot;
    logic [DIVD_W-1:0]          div_den;
    logic                       div_done;

    // Shared multiplier; it only ever squares its operand.
    always_comb begin
        case (cmd.op)
            imd_pkg::OP_SQ_X: mul_a = imd_pkg::MUL_W'(imd_pkg::mag16(ax_reg));
            imd_pkg::OP_SQ_Y: mul_a = imd_pkg::MUL_W'(imd_pkg::mag16(ay_reg));
            imd_pkg::OP_SQ_Z: mul_a = imd_pkg::MUL_W'(imd_pkg::mag16(az_reg));
            default:          mul_a = diff_reg;
        endcase
    end
    assign mul_p = imd_pkg::PROD_W'(mul_a) * imd_pkg::PROD_W'(mul_a);
    assign sum3  = acc_reg + prod_reg[imd_pkg::ACC_W-1:0];

    // Entries past the fill count hold no sample of the window and count as zero.
    assign norm_old = (norm_filled_reg == NF_W'(NORM_WINDOW)) ? norm_rd_reg : '0;
    assign dev_old  = (dev_filled_reg == DF_W'(DEVIATION_WINDOW)) ? dev_rd_reg : '0;
    assign rate_lim_ext = {2'b00, rate_limit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_low_reg   <= imd_pkg::NORM_LOW_RST;
            norm_high_reg  <= imd_pkg::NORM_HIGH_RST;
            var_limit_reg  <= imd_pkg::VARIANCE_LIMIT_RST;
            rate_limit_reg <= imd_pkg::RATE_LIMIT_RST;
        end else if (cfg_wr) begin
            case (imd_pkg::cfg_reg_t'(cfg_index))
                imd_pkg::REG_NORM_LOW:       norm_low_reg   <= cfg_data[NW-1:0];
                imd_pkg::REG_NORM_HIGH:      norm_high_reg  <= cfg_data[NW-1:0];
                imd_pkg::REG_VARIANCE_LIMIT: var_limit_reg  <= cfg_data[DW-1:0];
                imd_pkg::REG_RATE_LIMIT:     rate_limit_reg <= cfg_data[imd_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_total_reg  <= '0;
            dev_total_reg   <= '0;
            norm_filled_reg <= '0;
            dev_filled_reg  <= '0;
            norm_slot_reg   <= '0;
            dev_slot_reg    <= '0;
        end else begin
            case (cmd.op)
                imd_pkg::OP_NPUSH: begin
                    norm_total_reg <= norm_total_reg - NT_W'(norm_old) + NT_W'(norm_reg);
                    if (norm_filled_reg != NF_W'(NORM_WINDOW)) begin
                        norm_filled_reg <= norm_filled_reg + NF_W'(1);
                    end
                    norm_slot_reg <= (norm_slot_reg == NS_W'(NORM_WINDOW - 1)) ?
                                     '0 : norm_slot_reg + NS_W'(1);
                end
                imd_pkg::OP_DPUSH: begin
                    dev_total_reg <= dev_total_reg - DT_W'(dev_old) + DT_W'(prod_reg);
                    if (dev_filled_reg != DF_W'(DEVIATION_WINDOW)) begin
                        dev_filled_reg <= dev_filled_reg + DF_W'(1);
                    end
                    dev_slot_reg <= (dev_slot_reg == DS_W'(DEVIATION_WINDOW - 1)) ?
                                    '0 : dev_slot_reg + DS_W'(1);
                end
                default: ;
            endcase
        end
    end

    // History memories: one write port, one registered read at the current slot.
    always_ff @(posedge aclk) begin
        if (cmd.op == imd_pkg::OP_NPUSH) begin
            norm_mem[norm_slot_reg] <= norm_reg;
        end
        norm_rd_reg <= norm_mem[norm_slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == imd_pkg::OP_DPUSH) begin
            dev_mem[dev_slot_reg] <= prod_reg;
        end
        dev_rd_reg <= dev_mem[dev_slot_reg];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            imd_pkg::OP_CAPTURE: begin
                ax_reg <= s_tdata[0*SW +: SW];
                ay_reg <= s_tdata[1*SW +: SW];
                az_reg <= s_tdata[2*SW +: SW];
                rx_reg <= s_tdata[3*SW +: SW];
                ry_reg <= s_tdata[4*SW +: SW];
                rz_reg <= s_tdata[5*SW +: SW];
            end
            imd_pkg::OP_SQ_X: prod_reg <= mul_p;
            imd_pkg::OP_SQ_Y: begin
                prod_reg <= mul_p;
                acc_reg  <= prod_reg[imd_pkg::ACC_W-1:0];
            end
            imd_pkg::OP_SQ_Z: begin
                prod_reg <= mul_p;
                acc_reg  <= sum3;
            end
            imd_pkg::OP_NORM: begin
                norm_reg <= sum3[imd_pkg::Q_SHIFT +: NW];
                rot_reg  <= (imd_pkg::mag16(rx_reg) >= rate_lim_ext) ||
                            (imd_pkg::mag16(ry_reg) >= rate_lim_ext) ||
                            (imd_pkg::mag16(rz_reg) >= rate_lim_ext);
            end
            imd_pkg::OP_NPUSH: begin
                strong_reg <= (norm_reg < norm_low_reg) || (norm_reg > norm_high_reg);
            end
            imd_pkg::OP_NMEAN: mean_reg <= div_quot[NW-1:0];
            imd_pkg::OP_DIFF: begin
                diff_reg <= (norm_reg >= mean_reg) ? norm_reg - mean_reg
                                                   : mean_reg - norm_reg;
            end
            imd_pkg::OP_DSQ:   prod_reg <= mul_p;
            imd_pkg::OP_DMEAN: unsteady_reg <= div_quot >= DIVN_W'(var_limit_reg);
            imd_pkg::OP_RESULT: begin
                result_reg <= {4'b0000, rot_reg, unsteady_reg, strong_reg,
                               strong_reg | unsteady_reg | rot_reg};
            end
            default: ;
        endcase
    end

    // One divider serves both running means.
    assign div_start = (cmd.op == imd_pkg::OP_NDIV) || (cmd.op == imd_pkg::OP_DDIV);
    assign div_num   = (cmd.op == imd_pkg::OP_NDIV) ? DIVN_W'(norm_total_reg)
                                                    : DIVN_W'(dev_total_reg);
    assign div_den   = (cmd.op == imd_pkg::OP_NDIV) ? DIVD_W'(norm_filled_reg)
                                                    : DIVD_W'(dev_filled_reg);

    imd_div #(
        .NUM_W (DIVN_W),
        .DEN_W (DIVD_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    assign stat.div_done = div_done;
    assign result        = result_reg;

endmodule

>>> rtl/imd_ctrl.sv
// ============================================================================
// IMU motion detector controller
// Sequences one sample through the datapath and owns both handshakes.
// ============================================================================
module imd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output imd_pkg::dp_cmd_t    cmd,
    input  imd_pkg::dp_stat_t   stat
);

    imd_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= imd_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imd_pkg::ST_IDLE:  if (s_tvalid) state_next = imd_pkg::ST_SQ_X;
            imd_pkg::ST_SQ_X:  state_next = imd_pkg::ST_SQ_Y;
            imd_pkg::ST_SQ_Y:  state_next = imd_pkg::ST_SQ_Z;
            imd_pkg::ST_SQ_Z:  state_next = imd_pkg::ST_NORM;
            imd_pkg::ST_NORM:  state_next = imd_pkg::ST_NPUSH;
            imd_pkg::ST_NPUSH: state_next = imd_pkg::ST_NDIV;
            imd_pkg::ST_NDIV:  state_next = imd_pkg::ST_NWAIT;
            imd_pkg::ST_NWAIT: if (stat.div_done) state_next = imd_pkg::ST_DIFF;
            imd_pkg::ST_DIFF:  state_next = imd_pkg::ST_DSQ;
            imd_pkg::ST_DSQ:   state_next = imd_pkg::ST_DPUSH;
            imd_pkg::ST_DPUSH: state_next = imd_pkg::ST_DDIV;
            imd_pkg::ST_DDIV:  state_next = imd_pkg::ST_DWAIT;
            imd_pkg::ST_DWAIT: if (stat.div_done) state_next = imd_pkg::ST_DONE;
            imd_pkg::ST_DONE:  if (out_free) state_next = imd_pkg::ST_IDLE;
            default:           state_next = imd_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd.op        = imd_pkg::OP_NONE;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            imd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = imd_pkg::OP_CAPTURE;
            end
            imd_pkg::ST_SQ_X:  cmd.op = imd_pkg::OP_SQ_X;
            imd_pkg::ST_SQ_Y:  cmd.op = imd_pkg::OP_SQ_Y;
            imd_pkg::ST_SQ_Z:  cmd.op = imd_pkg::OP_SQ_Z;
            imd_pkg::ST_NORM:  cmd.op = imd_pkg::OP_NORM;
            imd_pkg::ST_NPUSH: cmd.op = imd_pkg::OP_NPUSH;
            imd_pkg::ST_NDIV:  cmd.op = imd_pkg::OP_NDIV;
            imd_pkg::ST_NWAIT: if (stat.div_done) cmd.op = imd_pkg::OP_NMEAN;
            imd_pkg::ST_DIFF:  cmd.op = imd_pkg::OP_DIFF;
            imd_pkg::ST_DSQ:   cmd.op = imd_pkg::OP_DSQ;
            imd_pkg::ST_DPUSH: cmd.op = imd_pkg::OP_DPUSH;
            imd_pkg::ST_DDIV:  cmd.op = imd_pkg::OP_DDIV;
            imd_pkg::ST_DWAIT: if (stat.div_done) cmd.op = imd_pkg::OP_DMEAN;
            imd_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.op        = imd_pkg::OP_RESULT;
                    m_tvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> test/tb.sv
// ============================================================================
// IMU motion detector testbench
// Streams IMU samples through the detector and checks every flag item
// against a cycle-free model of the norm band, variance and gyro tests.
// ============================================================================
// The test starts with a directed part: zero and full-scale axes, exact band
// and rate edges, and register extremes. It then runs several phases of
// random items under different register settings. Most random items form
// runs of a device at rest with gravity on one axis plus jitter and spin,
// which fill both windows and move the variance across its threshold. The
// rest are raw noise and short bursts of large accelerations. Both sides
// pause at random, and once the receiver holds off long enough to back the
// detector up into its input.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NORM_LEN     = 16;
    localparam int DEV_LEN      = 16;
    // This covers the time one item takes inside the detector.
    localparam int SETTLE       = 150;
    // The limit covers the slowest run: about 1150 items with the longest pauses
    // on both sides, plus the long receiver hold and the idle waits.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASES       = 6;
    localparam int HOLD_START   = 600;
    localparam int HOLD_CYCLES  = 500;

    // The four flags of one result item.
    typedef struct packed {
        logic rotating;
        logic accel_unsteady;
        logic strong_accel;
        logic moving;
    } motion_flags_t;

    // Predicts the flags of each accepted sample and holds them until the
    // matching result item comes out.
    class motion_scoreboard;
        logic [imd_pkg::NORM_W-1:0]  norm_low;
        logic [imd_pkg::NORM_W-1:0]  norm_high;
        logic [imd_pkg::DEV_W-1:0]   variance_limit;
        logic [imd_pkg::RATE_W-1:0]  rate_limit;
        longint unsigned    norm_ring[NORM_LEN];
        longint unsigned    norm_sum;
        int                 norm_count;
        int                 norm_pos;
        longint unsigned    dev_ring[DEV_LEN];
        longint unsigned    dev_sum;
        int                 dev_count;
        int                 dev_pos;
        motion_flags_t      expected_flags[$];
        int                 errors;
        int                 results;
        int                 strong_seen;
        int                 unsteady_seen;
        int                 rotating_seen;

        function new();
            norm_low       = imd_pkg::NORM_LOW_RST;
            norm_high      = imd_pkg::NORM_HIGH_RST;
            variance_limit = imd_pkg::VARIANCE_LIMIT_RST;
            rate_limit     = imd_pkg::RATE_LIMIT_RST;
            foreach (norm_ring[i]) norm_ring[i] = 0;
            foreach (dev_ring[i]) dev_ring[i] = 0;
            norm_sum   = 0;
            norm_count = 0;
            norm_pos   = 0;
            dev_sum    = 0;
            dev_count  = 0;
            dev_pos    = 0;
            errors     = 0;
            results    = 0;
            strong_seen   = 0;
            unsteady_seen = 0;
            rotating_seen = 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction

        // Bits above a register's width are dropped.
        function void set_reg(imd_pkg::cfg_reg_t idx, logic [imd_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                imd_pkg::REG_NORM_LOW:       norm_low       = v[imd_pkg::NORM_W-1:0];
                imd_pkg::REG_NORM_HIGH:      norm_high      = v[imd_pkg::NORM_W-1:0];
                imd_pkg::REG_VARIANCE_LIMIT: variance_limit = v[imd_pkg::DEV_W-1:0];
                imd_pkg::REG_RATE_LIMIT:     rate_limit     = v[imd_pkg::RATE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint rate_mag(logic signed [imd_pkg::SAMPLE_W-1:0] r);
            longint m;
            m = longint'(r);
            return (m < 0) ? -m : m;
        endfunction

        function void note_sample(logic [imd_pkg::S_TDATA_W-1:0] d);
            logic signed [imd_pkg::SAMPLE_W-1:0] ax;
            logic signed [imd_pkg::SAMPLE_W-1:0] ay;
            logic signed [imd_pkg::SAMPLE_W-1:0] az;
            longint          sq;
            longint unsigned norm;
            longint unsigned mean;
            longint unsigned spread;
            longint unsigned dev_mean;
            motion_flags_t   f;
            ax = d[15:0];
            ay = d[31:16];
            az = d[47:32];
            sq = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
               + longint'(az) * longint'(az);
            norm = longint'(sq) >> imd_pkg::Q_SHIFT;
            f.strong_accel = (norm < norm_low) || (norm > norm_high);

            // Ring of recent norms; the divisor counts up to the window.
            norm_sum = norm_sum - norm_ring[norm_pos] + norm;
            norm_ring[norm_pos] = norm;
            norm_pos = (norm_pos + 1) % NORM_LEN;
            if (norm_count < NORM_LEN) norm_count++;
            mean = norm_sum / longint'(norm_count);

            spread = (norm >= mean) ? norm - mean : mean - norm;
            dev_sum = dev_sum - dev_ring[dev_pos] + spread * spread;
            dev_ring[dev_pos] = spread * spread;
            dev_pos = (dev_pos + 1) % DEV_LEN;
            if (dev_count < DEV_LEN) dev_count++;
            dev_mean = dev_sum / longint'(dev_count);
            f.accel_unsteady = dev_mean >= variance_limit;

            f.rotating = (rate_mag(d[63:48]) >= rate_limit)
                      || (rate_mag(d[79:64]) >= rate_limit)
                      || (rate_mag(d[95:80]) >= rate_limit);
            f.moving = f.strong_accel || f.accel_unsteady || f.rotating;
            expected_flags.push_back(f);
        endfunction

        function void check_result(logic [imd_pkg::M_TDATA_W-1:0] t);
            motion_flags_t f;
            results++;
            if (expected_flags.size() == 0) begin
                report($sformatf("result %0d (tdata %h) arrived with none expected",
                                 results, t));
                return;
            end
            f = expected_flags.pop_front();
            if (t[0] !== f.moving)
                report($sformatf("result %0d moving %b, expected %b", results, t[0], f.moving));
            if (t[1] !== f.strong_accel)
                report($sformatf("result %0d strong_accel %b, expected %b",
                                 results, t[1], f.strong_accel));
            if (t[2] !== f.accel_unsteady)
                report($sformatf("result %0d accel_unsteady %b, expected %b",
                                 results, t[2], f.accel_unsteady));
            if (t[3] !== f.rotating)
                report($sformatf("result %0d rotating %b, expected %b",
                                 results, t[3], f.rotating));
            if (t[7:4] !== 4'b0000)
                report($sformatf("result %0d padding bits %b are not zero", results, t[7:4]));
            if (f.strong_accel)   strong_seen++;
            if (f.accel_unsteady) unsteady_seen++;
            if (f.rotating)       rotating_seen++;
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [imd_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [imd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [imd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [imd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  hold_off  = 1'b0;
    int                    cycles    = 0;
    int                    sent      = 0;
    int                    settings  = 1;
    int                    send_left = 0;
    bit                    send_calm = 1'b0;
    int                    sink_left = 0;
    bit                    sink_calm = 1'b0;

    motion_scoreboard sb = new();

    imu_motion_detector #(
        .NORM_WINDOW      (NORM_LEN),
        .DEVIATION_WINDOW (DEV_LEN)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Pause before one item, drawn at random. Runs of items alternate
    // between calm stretches with no pauses and stretches with random ones.
    function automatic int draw_gap(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(20, 60);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic int noise(int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic logic [imd_pkg::S_TDATA_W-1:0] pack_sample(int ax, int ay, int az,
                                                                int rx, int ry, int rz);
        return {16'(rz), 16'(ry), 16'(rx), 16'(az), 16'(ay), 16'(ax)};
    endfunction

    // A device at rest: gravity on one axis, jitter on the accelerometer
    // and a small spin on the gyro.
    function automatic logic [imd_pkg::S_TDATA_W-1:0] rest_sample(int axis, int sign,
                                                                int jitter, int spin);
        int a[3];
        int r[3];
        for (int i = 0; i < 3; i++) begin
            a[i] = noise(jitter);
            r[i] = noise(spin);
        end
        a[axis] += sign * 4096;
        return pack_sample(a[0], a[1], a[2], r[0], r[1], r[2]);
    endfunction

    // Fills the bits above a register's width with random junk, which the
    // detector must drop.
    function automatic logic [imd_pkg::CFG_DATA_W-1:0] with_junk(
        logic [imd_pkg::CFG_DATA_W-1:0] v, int w);
        logic [imd_pkg::CFG_DATA_W-1:0] junk;
        junk = imd_pkg::CFG_DATA_W'({$urandom, $urandom});
        junk = junk << w;
        return junk | v;
    endfunction

    task automatic send_sample(logic [imd_pkg::S_TDATA_W-1:0] d);
        int w;
        w = draw_gap(send_left, send_calm);
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(d);
        sent++;
    endtask

    task automatic write_reg(imd_pkg::cfg_reg_t idx, logic [imd_pkg::CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    // Waits until every result is out and the detector has had time to
    // go idle.
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Registers change only while no item is in flight.
    task automatic configure(logic [imd_pkg::CFG_DATA_W-1:0] nl,
                             logic [imd_pkg::CFG_DATA_W-1:0] nh,
                             logic [imd_pkg::CFG_DATA_W-1:0] vl,
                             logic [imd_pkg::CFG_DATA_W-1:0] rl);
        s_tvalid <= 1'b0;
        wait_idle();
        write_reg(imd_pkg::REG_NORM_LOW, nl);
        write_reg(imd_pkg::REG_NORM_HIGH, nh);
        write_reg(imd_pkg::REG_VARIANCE_LIMIT, vl);
        write_reg(imd_pkg::REG_RATE_LIMIT, rl);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Mostly runs at rest with random jitter and spin; some raw noise and
    // some bursts of large accelerations.
    task automatic random_run(int count);
        int start;
        int kind;
        int axis;
        int sign;
        int jitter;
        int spin;
        int len;
        start = sent;
        while (sent - start < count) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                axis = $urandom_range(0, 2);
                sign = $urandom_range(0, 1) ? 1 : -1;
                case ($urandom_range(0, 3))
                    0: jitter = 4;
                    1: jitter = 30;
                    2: jitter = 120;
                    default: jitter = 600;
                endcase
                case ($urandom_range(0, 2))
                    0: spin = 10;
                    1: spin = 90;
                    default: spin = 400;
                endcase
                len = $urandom_range(8, 40);
                repeat (len) send_sample(rest_sample(axis, sign, jitter, spin));
            end else if (kind == 7) begin
                len = $urandom_range(1, 6);
                repeat (len) send_sample({$urandom, $urandom, $urandom});
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) send_sample(pack_sample(noise(32767), noise(32767),
                                                     noise(32767), noise(200),
                                                     noise(200), noise(200)));
            end
        end
    endtask

    // Result side: random pauses, and the long hold below.
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            w = draw_gap(sink_left, sink_calm);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            forever begin
                m_tready <= !hold_off;
                @(posedge aclk);
                if (m_tready && m_tvalid) break;
            end
            sb.check_result(m_tdata);
        end
    end

    // Once during the random part the receiver stops taking results for a
    // long stretch, while samples keep coming, so the input backs up.
    initial begin
        wait (sent >= HOLD_START);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero and full-scale axes, band and rate edges.
        send_sample(pack_sample(0, 0, 0, 0, 0, 0));
        send_sample(pack_sample(0, 0, 4096, 0, 0, 0));
        send_sample(pack_sample(-32768, -32768, -32768, 0, 0, 0));
        send_sample(pack_sample(32767, 32767, 32767, 0, 0, 0));
        send_sample(pack_sample(-32768, 32767, 0, -32768, 0, 0));
        send_sample(pack_sample(0, 4096, 0, 32767, 0, 0));
        send_sample(pack_sample(0, 0, -4096, 0, 82, 0));
        send_sample(pack_sample(0, 0, -4096, 0, 0, 81));
        send_sample(pack_sample(0, 0, -4096, 0, 0, -82));
        send_sample(pack_sample(0, 0, -4096, -81, 81, -81));
        // Norms of 3481 and 3482 straddle the lower band edge, 4710 and
        // 4711 the upper one.
        send_sample(pack_sample(0, 0, 3776, 0, 0, 0));
        send_sample(pack_sample(0, 0, 3777, 0, 0, 0));
        send_sample(pack_sample(50, 0, 4392, 0, 0, 0));
        send_sample(pack_sample(0, 0, 4393, 0, 0, 0));

        // Widest band, highest thresholds: nothing but the largest rates
        // can raise a flag.
        configure(with_junk(40'd0, imd_pkg::NORM_W), {imd_pkg::CFG_DATA_W{1'b1}},
                  {imd_pkg::CFG_DATA_W{1'b1}}, {imd_pkg::CFG_DATA_W{1'b1}});
        send_sample(pack_sample(32767, -32768, 32767, -32768, 32767, 1));
        send_sample({$urandom, $urandom, $urandom});

        // Band narrowed to the largest norm, gyro limit at full scale.
        configure(with_junk(40'd786432, imd_pkg::NORM_W),
                  with_junk(40'd786432, imd_pkg::NORM_W),
                  40'd1, with_junk(40'd32767, imd_pkg::RATE_W));
        send_sample(pack_sample(-32768, -32768, -32768, 0, 0, 0));
        send_sample(pack_sample(32767, 32767, 32767, 0, 0, 0));
        send_sample(pack_sample(0, 0, 4096, -32768, 0, 0));
        send_sample(pack_sample(0, 0, 4096, 32767, 32766, -32767));
        send_sample(pack_sample(0, 0, 4096, 32766, -32767, 32766));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(with_junk(40'd3482, imd_pkg::NORM_W),
                             with_junk(40'd4710, imd_pkg::NORM_W),
                             40'd8389, with_junk(40'd82, imd_pkg::RATE_W));
                1: configure(40'd0, 40'd0, 40'd0, 40'd0);
                // Inverted band: every norm counts as strong.
                2: configure(with_junk(40'd4710, imd_pkg::NORM_W),
                             with_junk(40'd3482, imd_pkg::NORM_W),
                             40'd20000, with_junk(40'd100, imd_pkg::RATE_W));
                5: configure(40'd3482, 40'd4710, 40'd8389, 40'd82);
                default: configure(
                    with_junk(40'(3000 + $urandom_range(0, 1000)), imd_pkg::NORM_W),
                    with_junk(40'(4300 + $urandom_range(0, 1200)), imd_pkg::NORM_W),
                    40'($urandom_range(0, 200000)),
                    with_junk(40'($urandom_range(20, 300)), imd_pkg::RATE_W));
            endcase
            random_run(RANDOM_ITEMS / PHASES);
        end

        s_tvalid <= 1'b0;
        wait_idle();

        $display("Checked %0d results from %0d samples under %0d register settings.",
                 sb.results, sent, settings);
        $display("Flags seen: strong_accel %0d, accel_unsteady %0d, rotating %0d.",
                 sb.strong_seen, sb.unsteady_seen, sb.rotating_seen);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/imd_pkg.sv
rtl/imd_div.sv
rtl/imd_datapath.sv
rtl/imd_ctrl.sv
rtl/imu_motion_detector.sv
test/tb.sv
